[design/fwrl_pkg.sv]
// shared types and constants for the per-client fixed-window rate limiter
package fwrl_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_BITS      = 32;
  localparam int SLOT_BITS     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // only the low KEY_BITS of the 32-bit client key take part
  localparam int KEY_W         = (KEY_BITS < 32) ? KEY_BITS : 32;

  // configuration registers
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PER_WINDOW = 1'd1;
  localparam logic [15:0] WINDOW_LENGTH_RESET  = 16'd60;
  localparam logic [15:0] MAX_PER_WINDOW_RESET = 16'd100;

  typedef logic [SLOT_BITS-1:0] slot_idx_t;
  typedef logic [KEY_W-1:0]     slot_key_t;

  // result codes
  typedef enum logic [1:0] {
    OUTCOME_NEW_WINDOW = 2'd0,
    OUTCOME_COUNTED    = 2'd1,
    OUTCOME_LIMIT      = 2'd2,
    OUTCOME_TABLE_FULL = 2'd3
  } outcome_t;

  // what the key lookup found
  typedef enum logic [1:0] {
    LOOKUP_HIT,
    LOOKUP_NEW,
    LOOKUP_FULL
  } lookup_t;

  typedef struct packed {
    logic [31:0] client_key;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic     allowed;
    outcome_t outcome;
  } resp_t;

  // per-slot window state kept in memory
  typedef struct packed {
    logic [31:0] window_start;
    logic [15:0] count;
  } slot_entry_t;

endpackage

[design/per_client_fixed_window_rate_limiter.sv]
// per-client fixed-window rate limiter: key lookup, window update and result
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+--------------------------
//  in      | in_valid / in_ready / in_data  | input     | client_key, now_seconds
//  out     | out_valid / out_ready / out_data | output  | allowed, outcome
//  cfg     | cfg_we / cfg_index / cfg_data  | input     | window_length, max_per_window
//
// one request per cycle sustained while the output is not stalled; the result passes the
// input register, the lookup/read stage and the result register. the key compare runs over
// all slot keys in flip-flops; window state sits in a one-read one-write memory
// with a bypass for the slot written by the request just ahead.
// rst is synchronous: table emptied, registers to 60 s / 100 requests.
// a stalled output holds each stage with no empty stage ahead; in_ready drops only while out_valid waits.
module per_client_fixed_window_rate_limiter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  fwrl_pkg::req_t                         in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output fwrl_pkg::resp_t                        out_data,
  input  logic                                   cfg_we,
  input  logic [fwrl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [fwrl_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  // configuration
  logic [15:0] window_length;
  logic [15:0] max_per_window;

  // slot keys and valid bits (flip-flops, compared in parallel)
  logic                  slot_valid [fwrl_pkg::TABLE_ENTRIES];
  fwrl_pkg::slot_key_t   slot_key   [fwrl_pkg::TABLE_ENTRIES];

  // window state memory
  fwrl_pkg::slot_entry_t slot_mem   [fwrl_pkg::TABLE_ENTRIES];
  fwrl_pkg::slot_entry_t rd_entry;
  fwrl_pkg::slot_entry_t fwd_entry;
  logic                  fwd_hit;

  // input stage
  logic                  r0_valid;
  fwrl_pkg::slot_key_t   r0_key;
  logic [31:0]           r0_now;

  // lookup stage
  logic                  r1_valid;
  fwrl_pkg::lookup_t     r1_lookup;
  fwrl_pkg::slot_idx_t   r1_idx;
  logic [31:0]           r1_now;

  // handshake / advance
  logic r0_adv;
  logic r1_adv;

  // lookup results
  logic                  hit;
  fwrl_pkg::slot_idx_t   hit_idx;
  logic                  free_found;
  fwrl_pkg::slot_idx_t   free_idx;
  fwrl_pkg::lookup_t     lookup;
  fwrl_pkg::slot_idx_t   rd_addr;

  // update stage
  fwrl_pkg::slot_entry_t cur_entry;
  logic [31:0]           elapsed;
  logic                  mem_we;
  fwrl_pkg::slot_entry_t wr_entry;
  fwrl_pkg::resp_t       resp_next;

  // pipeline flow
  assign r1_adv   = r1_valid && (!out_valid || out_ready);
  assign r0_adv   = r0_valid && (!r1_valid || r1_adv);
  assign in_ready = !r0_valid || r0_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= fwrl_pkg::WINDOW_LENGTH_RESET;
      max_per_window <= fwrl_pkg::MAX_PER_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fwrl_pkg::CFG_WINDOW_LENGTH:  window_length  <= cfg_data;
        fwrl_pkg::CFG_MAX_PER_WINDOW: max_per_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (in_ready) begin
      r0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r0_key <= in_data.client_key[fwrl_pkg::KEY_W-1:0];
      r0_now <= in_data.now_seconds;
    end
  end

  // parallel key match, keys are unique so matches are or-ed together
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < fwrl_pkg::TABLE_ENTRIES; i++) begin
      if (slot_valid[i] && (slot_key[i] == r0_key)) begin
        hit     = 1'b1;
        hit_idx = hit_idx | fwrl_pkg::slot_idx_t'(i);
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = fwrl_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = fwrl_pkg::slot_idx_t'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      lookup  = fwrl_pkg::LOOKUP_HIT;
      rd_addr = hit_idx;
    end else if (free_found) begin
      lookup  = fwrl_pkg::LOOKUP_NEW;
      rd_addr = free_idx;
    end else begin
      lookup  = fwrl_pkg::LOOKUP_FULL;
      rd_addr = free_idx;
    end
  end

  // claim a slot for a new key as the request leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fwrl_pkg::TABLE_ENTRIES; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else if (r0_adv && (lookup == fwrl_pkg::LOOKUP_NEW)) begin
      slot_valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (r0_adv && (lookup == fwrl_pkg::LOOKUP_NEW)) begin
      slot_key[free_idx] <= r0_key;
    end
  end

  // lookup stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (!r1_valid || r1_adv) begin
      r1_valid <= r0_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (r0_adv) begin
      r1_lookup <= lookup;
      r1_idx    <= rd_addr;
      r1_now    <= r0_now;
    end
  end

  // window state memory, read as the request enters the lookup stage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[r1_idx] <= wr_entry;
    end
    if (r0_adv) begin
      rd_entry <= slot_mem[rd_addr];
    end
  end

  // bypass when the request ahead writes the slot being read
  always_ff @(posedge clk) begin
    if (r0_adv) begin
      fwd_hit   <= mem_we && (r1_idx == rd_addr);
      fwd_entry <= wr_entry;
    end
  end

  assign cur_entry = fwd_hit ? fwd_entry : rd_entry;
  assign elapsed   = r1_now - cur_entry.window_start;

  // window decision and slot update
  always_comb begin
    mem_we                = 1'b0;
    wr_entry.window_start = r1_now;
    wr_entry.count        = 16'd1;
    resp_next.allowed     = 1'b1;
    resp_next.outcome     = fwrl_pkg::OUTCOME_NEW_WINDOW;
    case (r1_lookup)
      fwrl_pkg::LOOKUP_NEW: begin
        mem_we = r1_adv;
      end
      fwrl_pkg::LOOKUP_HIT: begin
        if (elapsed >= {16'd0, window_length}) begin
          mem_we = r1_adv;
        end else if (cur_entry.count < max_per_window) begin
          mem_we                = r1_adv;
          wr_entry.window_start = cur_entry.window_start;
          wr_entry.count        = cur_entry.count + 16'd1;
          resp_next.outcome     = fwrl_pkg::OUTCOME_COUNTED;
        end else begin
          resp_next.allowed = 1'b0;
          resp_next.outcome = fwrl_pkg::OUTCOME_LIMIT;
        end
      end
      default: begin
        resp_next.allowed = 1'b0;
        resp_next.outcome = fwrl_pkg::OUTCOME_TABLE_FULL;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1_adv) begin
      out_data <= resp_next;
    end
  end

endmodule

[design/fwrl_checker.sv]
// port-level checks for the rate limiter, bound to the top level
module fwrl_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input fwrl_pkg::resp_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // allowed flag agrees with the outcome code
  a_allowed_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.allowed ==
      ((out_data.outcome == fwrl_pkg::OUTCOME_NEW_WINDOW) ||
       (out_data.outcome == fwrl_pkg::OUTCOME_COUNTED))))
    else $error("allowed flag does not match outcome");

  // request side backs up only behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request side stalled without output stall");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind per_client_fixed_window_rate_limiter fwrl_checker u_fwrl_checker (.*);

[verif/per_client_fixed_window_rate_limiter_test.sv]
// self-checking testbench for the per-client fixed-window rate limiter
module per_client_fixed_window_rate_limiter_test;

  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LIMIT    = 2000000;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  fwrl_pkg::req_t                      in_data = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  fwrl_pkg::resp_t                     out_data;
  logic                                cfg_we = 1'b0;
  logic [fwrl_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [fwrl_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  // rate limiter as the block should see it
  logic                slot_used [fwrl_pkg::TABLE_ENTRIES];
  fwrl_pkg::slot_key_t slot_client [fwrl_pkg::TABLE_ENTRIES];
  logic [31:0]         slot_start [fwrl_pkg::TABLE_ENTRIES];
  logic [15:0]         slot_hits [fwrl_pkg::TABLE_ENTRIES];
  logic [15:0]         window_len_cfg = fwrl_pkg::WINDOW_LENGTH_RESET;
  logic [15:0]         max_hits_cfg   = fwrl_pkg::MAX_PER_WINDOW_RESET;

  fwrl_pkg::req_t      pending_reqs[$];
  fwrl_pkg::resp_t     expected_resps[$];
  logic [31:0]         key_pool[$];
  logic [31:0]         sim_now = '0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  mismatches = 0;

  per_client_fixed_window_rate_limiter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
    end
  end

  // decide one request against the table and update it
  function automatic fwrl_pkg::resp_t admit_request(fwrl_pkg::req_t r);
    fwrl_pkg::slot_key_t key;
    int                  hit;
    int                  free_slot;
    logic [31:0]         elapsed;
    fwrl_pkg::resp_t     res;
    key       = r.client_key[fwrl_pkg::KEY_W-1:0];
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < fwrl_pkg::TABLE_ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_client[i] == key) begin
          hit = i;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        res.allowed = 1'b0;
        res.outcome = fwrl_pkg::OUTCOME_TABLE_FULL;
      end else begin
        slot_used[free_slot]   = 1'b1;
        slot_client[free_slot] = key;
        slot_start[free_slot]  = r.now_seconds;
        slot_hits[free_slot]   = 16'd1;
        res.allowed = 1'b1;
        res.outcome = fwrl_pkg::OUTCOME_NEW_WINDOW;
      end
    end else begin
      elapsed = r.now_seconds - slot_start[hit];
      if (elapsed >= {16'd0, window_len_cfg}) begin
        slot_start[hit] = r.now_seconds;
        slot_hits[hit]  = 16'd1;
        res.allowed = 1'b1;
        res.outcome = fwrl_pkg::OUTCOME_NEW_WINDOW;
      end else if (slot_hits[hit] < max_hits_cfg) begin
        slot_hits[hit] = slot_hits[hit] + 16'd1;
        res.allowed = 1'b1;
        res.outcome = fwrl_pkg::OUTCOME_COUNTED;
      end else begin
        res.allowed = 1'b0;
        res.outcome = fwrl_pkg::OUTCOME_LIMIT;
      end
    end
    return res;
  endfunction

  // request driver: predicts on accept, then offers the next pending request
  always @(posedge clk) begin : request_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_resps.push_back(admit_request(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor with random back-pressure
  always @(posedge clk) begin : response_monitor
    fwrl_pkg::resp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: response with none expected: allowed=%0b outcome=%0d",
                   $time, out_data.allowed, out_data.outcome);
          mismatches++;
        end else begin
          want = expected_resps.pop_front();
          if (out_data.allowed !== want.allowed) begin
            $display("%0t: allowed mismatch: expected %0b, got %0b",
                     $time, want.allowed, out_data.allowed);
            mismatches++;
          end
          if (out_data.outcome !== want.outcome) begin
            $display("%0t: outcome mismatch: expected %0d, got %0d",
                     $time, want.outcome, out_data.outcome);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(logic [31:0] key, logic [31:0] now);
    fwrl_pkg::req_t r;
    r.client_key  = key;
    r.now_seconds = now;
    pending_reqs.push_back(r);
  endtask

  // wait until every request is sent and answered, then let the pipe settle
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [fwrl_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [fwrl_pkg::CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fwrl_pkg::CFG_WINDOW_LENGTH) begin
      window_len_cfg = val;
    end else begin
      max_hits_cfg = val;
    end
  endtask

  task automatic configure(logic [15:0] win, logic [15:0] cap);
    write_reg(fwrl_pkg::CFG_WINDOW_LENGTH, win);
    write_reg(fwrl_pkg::CFG_MAX_PER_WINDOW, cap);
    @(negedge clk);
  endtask

  // random traffic: mostly recent clients, slowly moving clock with jumps
  task automatic add_random(int count, int new_pct);
    logic [31:0] key;
    int          span;
    int          r;
    repeat (count) begin
      if (key_pool.size() == 0 || $urandom_range(99) < new_pct) begin
        key = $urandom();
        key_pool.push_back(key);
      end else if ($urandom_range(99) < 85) begin
        span = (key_pool.size() < 8) ? key_pool.size() : 8;
        key  = key_pool[key_pool.size() - 1 - $urandom_range(span - 1)];
      end else begin
        key = key_pool[$urandom_range(key_pool.size() - 1)];
      end
      r = $urandom_range(99);
      if (r < 4) begin
        sim_now = sim_now - $urandom_range(1, 1000);
      end else if (r < 9) begin
        sim_now = sim_now + window_len_cfg + $urandom_range(0, 2);
      end else if (r < 11) begin
        sim_now = $urandom();
      end else if (r < 40) begin
        sim_now = sim_now + 1;
      end
      add_req(key, sim_now);
    end
  endtask

  initial begin : stimulus
    int free_slots;
    logic [31:0] key;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: 60 s window edge, clock wrap, time going back, 100 cap
    add_req(32'h0, 32'h0);
    add_req(32'h0, 32'd59);
    add_req(32'h0, 32'd60);
    add_req(32'hffffffff, 32'hffffffff);
    add_req(32'hffffffff, 32'h0);
    add_req(32'hffffffff, 32'd59);
    add_req(32'hffffffff, 32'd10);
    repeat (100) add_req(32'h0, 32'd61);
    wait_drained();

    // zero window length: every request opens a window
    configure(16'd0, 16'd1);
    add_req(32'h0, 32'd61);
    add_req(32'h0, 32'd61);
    add_req(32'hffffffff, 32'd10);
    wait_drained();

    // zero maximum: first request of a window only
    configure(16'd5, 16'd0);
    add_req(32'ha5a5a5a5, 32'd100);
    add_req(32'ha5a5a5a5, 32'd101);
    add_req(32'ha5a5a5a5, 32'd104);
    add_req(32'ha5a5a5a5, 32'd105);
    add_req(32'h5a5a5a5a, 32'h7fffffff);
    add_req(32'h5a5a5a5a, 32'h80000000);
    wait_drained();

    // largest window, small cap
    configure(16'hffff, 16'd2);
    add_req(32'h12345678, 32'd0);
    add_req(32'h12345678, 32'd65534);
    add_req(32'h12345678, 32'd65534);
    add_req(32'h12345678, 32'd65535);
    add_req(32'h12345678, 32'hffffffff);
    wait_drained();

    // random traffic under several settings and idle patterns
    sim_now = $urandom();
    configure(16'd10, 16'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random(120, 8);
    wait_drained();

    configure(16'd1, 16'd1);
    send_idle_pct  = 58;
    recv_stall_pct = 0;
    add_random(110, 8);
    wait_drained();

    configure(16'd0, 16'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    add_random(60, 5);
    wait_drained();

    configure(16'hffff, 16'hffff);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    add_random(110, 15);
    wait_drained();

    // fill the table to the brim and beyond, then keep going
    configure(16'd20, 16'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    free_slots = 0;
    foreach (slot_used[i]) begin
      if (!slot_used[i]) free_slots++;
    end
    repeat (free_slots + 3) begin
      key = $urandom();
      key_pool.push_back(key);
      add_req(key, sim_now);
      sim_now = sim_now + 1;
    end
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    add_random(60, 8);
    // sender holds off until the pipe is empty
    wait_drained();
    add_random(60, 8);
    wait_drained();

    configure(16'd7, 16'd4);
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    add_random(50, 10);
    wait_drained();

    configure(16'd3, 16'd1);
    send_idle_pct  = 58;
    recv_stall_pct = 58;
    add_random(50, 10);
    wait_drained();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
